>>> src/bba_pkg.sv
// Shared constants and types for the buddy block allocator.
`default_nettype none
package bba_pkg;

    localparam int ENTRIES    = 512;
    localparam int UNIT_BYTES = 32;
    localparam int HEAP_BYTES = ENTRIES * UNIT_BYTES;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int UNIT_SH    = $clog2(UNIT_BYTES);
    localparam int ENTRY_W    = $clog2(HEAP_BYTES) + 2;
    localparam int REQ_W      = 15;
    localparam int SIZE_W     = REQ_W + 1;
    localparam int ADDR_W     = 32;

    localparam logic [31:0] HEAP_BASE_RESET = 32'h2000_1000;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOTALLOC = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
    } res_t;

endpackage
`default_nettype wire

>>> src/bba_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

>>> src/bba_engine.sv
// Sequencer and shared datapath that walks and updates the block table.
`default_nettype none
module bba_engine (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [31:0]           heap_base,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  cmd,
    input  wire logic [bba_pkg::REQ_W-1:0] req_size,
    input  wire logic [31:0]           free_addr,
    input  wire logic                  res_take,
    output bba_pkg::res_t              res
);
    import bba_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LEVEL  = 4'd2;
    localparam logic [3:0] S_ARD    = 4'd3;
    localparam logic [3:0] S_ACHK   = 4'd4;
    localparam logic [3:0] S_ASPL   = 4'd5;
    localparam logic [3:0] S_AMW    = 4'd6;
    localparam logic [3:0] S_FRD    = 4'd7;
    localparam logic [3:0] S_FCHK   = 4'd8;
    localparam logic [3:0] S_MWR    = 4'd9;
    localparam logic [3:0] S_MBRD   = 4'd10;
    localparam logic [3:0] S_MBCHK  = 4'd11;
    localparam logic [3:0] S_MW2    = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    logic [3:0]         state_reg, state_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   bud_reg, bud_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [ENTRY_W-1:0] cur_reg, cur_next;
    logic               even_reg, even_next;
    logic [31:0]        faddr_reg, faddr_next;
    logic [1:0]         status_reg, status_next;
    logic [31:0]        addr_reg, addr_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [SIZE_W-1:0]  size_in;
    logic [31:0]        offset;
    logic [31:0]        half_bytes;
    logic [ENTRY_W-1:0] cnt_bytes;
    logic [CNT_W-1:0]   scan_next;
    logic [IDX_W-1:0]   cnt_lo;
    logic [IDX_W-1:0]   mid;
    logic [ENTRY_W-1:0] disp;
    logic [ENTRY_W-1:0] bud_sum;
    logic               even;

    bba_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign size_in    = (req_size < REQ_W'(UNIT_BYTES)) ? SIZE_W'(UNIT_BYTES)
                                                        : SIZE_W'(req_size);
    assign offset     = free_addr - heap_base;
    assign half_bytes = 32'(cnt_reg >> 1) << UNIT_SH;
    assign cnt_bytes  = ENTRY_W'(cnt_reg) << UNIT_SH;
    assign scan_next  = CNT_W'(idx_reg) + cnt_reg;
    assign cnt_lo     = cnt_reg[IDX_W-1:0];
    assign mid        = (idx_reg & ~(cnt_lo - IDX_W'(1))) | cnt_lo;
    assign disp       = cur_reg >> UNIT_SH;
    assign bud_sum    = ENTRY_W'(idx_reg) + disp;
    assign even       = (disp >= ENTRY_W'(ENTRIES)) || ((idx_reg & disp[IDX_W-1:0]) == '0);

    assign in_ready   = (state_reg == S_IDLE);
    assign res.valid  = (state_reg == S_FIN);
    assign res.status = status_reg;
    assign res.addr   = addr_reg;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        bud_next    = bud_reg;
        cnt_next    = cnt_reg;
        size_next   = size_reg;
        cur_next    = cur_reg;
        even_next   = even_reg;
        faddr_next  = faddr_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        ram_we      = 1'b0;
        ram_addr    = idx_reg;
        ram_wdata   = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = (clr_reg == '0) ? ENTRY_W'(HEAP_BYTES) : '0;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    faddr_next = free_addr;
                    addr_next  = '0;
                    if (cmd == CMD_ALLOC)
                    begin
                        size_next = size_in;
                        cnt_next  = CNT_W'(ENTRIES);
                        if (32'(size_in) > 32'(HEAP_BYTES))
                        begin
                            status_next = ST_NOSPACE;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_LEVEL;
                        end
                    end
                    else
                    begin
                        idx_next = offset[UNIT_SH +: IDX_W];
                        if (offset >= 32'(HEAP_BYTES))
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_FRD;
                        end
                    end
                end
            end
            S_LEVEL:
            begin
                if (cnt_reg > CNT_W'(1) && 32'(size_reg) <= half_bytes)
                begin
                    cnt_next = cnt_reg >> 1;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (!ram_rdata[0] && ram_rdata >= cnt_bytes)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = cnt_bytes | ENTRY_W'(1);
                    state_next = S_ASPL;
                end
                else if (scan_next >= CNT_W'(ENTRIES))
                begin
                    status_next = ST_NOSPACE;
                    state_next  = S_FIN;
                end
                else
                begin
                    idx_next   = scan_next[IDX_W-1:0];
                    state_next = S_ARD;
                end
            end
            S_ASPL:
            begin
                if (cnt_reg >= CNT_W'(ENTRIES))
                begin
                    status_next = ST_OK;
                    addr_next   = heap_base + (32'(idx_reg) << UNIT_SH);
                    state_next  = S_FIN;
                end
                else if ((idx_reg & cnt_lo) == '0)
                begin
                    ram_addr   = mid;
                    bud_next   = mid;
                    state_next = S_AMW;
                end
                else
                begin
                    cnt_next = cnt_reg << 1;
                end
            end
            S_AMW:
            begin
                ram_addr = bud_reg;
                if (ram_rdata == '0)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = cnt_bytes;
                end
                cnt_next   = cnt_reg << 1;
                state_next = S_ASPL;
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (!ram_rdata[0])
                begin
                    status_next = ST_NOTALLOC;
                    state_next  = S_FIN;
                end
                else
                begin
                    cur_next   = ram_rdata & ~ENTRY_W'(1);
                    state_next = S_MWR;
                end
            end
            S_MWR:
            begin
                ram_we    = 1'b1;
                ram_wdata = cur_reg;
                even_next = even;
                status_next = ST_OK;
                addr_next   = faddr_reg;
                if (disp == '0)
                begin
                    state_next = S_FIN;
                end
                else if (even)
                begin
                    if (bud_sum >= ENTRY_W'(ENTRIES))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        bud_next   = bud_sum[IDX_W-1:0];
                        state_next = S_MBRD;
                    end
                end
                else if (ENTRY_W'(idx_reg) < disp)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    bud_next   = idx_reg - disp[IDX_W-1:0];
                    state_next = S_MBRD;
                end
            end
            S_MBRD:
            begin
                ram_addr   = bud_reg;
                state_next = S_MBCHK;
            end
            S_MBCHK:
            begin
                if (ram_rdata != cur_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_addr   = even_reg ? bud_reg : idx_reg;
                    state_next = S_MW2;
                end
            end
            S_MW2:
            begin
                ram_we    = 1'b1;
                ram_addr  = even_reg ? idx_reg : bud_reg;
                ram_wdata = cur_reg << 1;
                cur_next  = cur_reg << 1;
                if (!even_reg)
                begin
                    idx_next = bud_reg;
                end
                state_next = S_MWR;
            end
            S_FIN:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        bud_reg    <= bud_next;
        cnt_reg    <= cnt_next;
        size_reg   <= size_next;
        cur_reg    <= cur_next;
        even_reg   <= even_next;
        faddr_reg  <= faddr_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
    end

endmodule
`default_nettype wire

>>> src/buddy_block_allocator_unit.sv
// Top level of the buddy block allocator: config register, engine and output register.
// Allocate: scans the table for a free block, then splits it down level by level.
// Free: clears the block, then merges it with its buddy step by step; one request at a time.
// Both use the single table port that the sequencer shares for every read and write.
// After reset a clearing pass initializes all 512 table entries; no transfer is taken meanwhile.
// heap_base resets to 0x20001000.
`default_nettype none
module buddy_block_allocator_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [31:0]               cfg_wdata,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      cmd,
    input  wire logic [bba_pkg::REQ_W-1:0] req_size,
    input  wire logic [31:0]               free_addr,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [1:0]                     status,
    output logic [31:0]                    result_addr
);
    import bba_pkg::*;

    logic [31:0] heap_base_reg;
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] addr_reg;
    logic        res_take;
    res_t        res;

    assign res_take = !out_valid_reg || out_ready;

    bba_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .heap_base(heap_base_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .req_size (req_size),
        .free_addr(free_addr),
        .res_take (res_take),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= HEAP_BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                heap_base_reg <= cfg_wdata;
            end
            if (res_take)
            begin
                out_valid_reg <= res.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res.valid)
        begin
            status_reg <= res.status;
            addr_reg   <= res.addr;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign result_addr = addr_reg;

endmodule
`default_nettype wire

>>> tb/bba_checker.sv
// Checker for the buddy block allocator: watches both channels, predicts each result and compares.
`default_nettype none
module bba_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        cmd,
    input  wire logic [bba_pkg::REQ_W-1:0] req_size,
    input  wire logic [31:0] free_addr,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  status,
    input  wire logic [31:0] result_addr,
    output int               fail_count,
    output int               pending
);
    import bba_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] addr;
    } alloc_result_t;

    logic [31:0]   unit_table [ENTRIES];
    logic [31:0]   base_addr;
    alloc_result_t result_fifo [$];

    function automatic bit place_block(input logic [31:0] size, input int left, input int n,
                                       output int where);
        int half;
        int mid;
        half = n >> 1;
        if (left >= ENTRIES)
            return 0;
        if (half != 0 && size <= half * UNIT_BYTES) begin
            if (place_block(size, left, half, where)) begin
                mid = left + half;
                if (mid < ENTRIES && unit_table[mid] == 0)
                    unit_table[mid] = half * UNIT_BYTES;
                return 1;
            end
            return place_block(size, left + half, half, where);
        end
        if (unit_table[left][0])
            return 0;
        if (unit_table[left] < n * UNIT_BYTES)
            return 0;
        unit_table[left] = (n * UNIT_BYTES) | 1;
        where = left;
        return 1;
    endfunction

    function automatic void release_block(input int start);
        int idx;
        int disp;
        int buddy;
        logic [31:0] size;
        idx = start;
        forever begin
            size = unit_table[idx] & ~32'h1;
            disp = size / UNIT_BYTES;
            unit_table[idx] = size;
            if (disp == 0)
                return;
            if (((idx / disp) & 1) == 0) begin
                buddy = idx + disp;
                if (buddy >= ENTRIES)
                    return;
                if (unit_table[buddy][0] || unit_table[buddy] != size)
                    return;
                unit_table[buddy] = 0;
                unit_table[idx] = size * 2;
            end
            else begin
                if (idx < disp)
                    return;
                buddy = idx - disp;
                if (unit_table[buddy][0] || unit_table[buddy] != size)
                    return;
                unit_table[idx] = 0;
                unit_table[buddy] = size * 2;
                idx = buddy;
            end
        end
    endfunction

    function automatic alloc_result_t predict_request(input logic c, input logic [REQ_W-1:0] rs,
                                                      input logic [31:0] fa);
        alloc_result_t r;
        logic [31:0] size;
        logic [31:0] offset;
        int where;
        r = '0;
        if (c == CMD_ALLOC) begin
            size = 32'(rs);
            if (size < UNIT_BYTES)
                size = UNIT_BYTES;
            if (size > HEAP_BYTES || !place_block(size, 0, ENTRIES, where))
                r.status = ST_NOSPACE;
            else
                r.addr = base_addr + where * UNIT_BYTES;
        end
        else begin
            offset = fa - base_addr;
            if (offset >= HEAP_BYTES)
                r.status = ST_RANGE;
            else if (!unit_table[offset / UNIT_BYTES][0])
                r.status = ST_NOTALLOC;
            else begin
                release_block(offset / UNIT_BYTES);
                r.addr = fa;
            end
        end
        return r;
    endfunction

    assign pending = result_fifo.size();

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < ENTRIES; i++)
                unit_table[i] = 0;
            unit_table[0] = HEAP_BYTES;
            base_addr = HEAP_BASE_RESET;
            result_fifo.delete();
            fail_count <= 0;
        end
        else begin
            if (cfg_we)
                base_addr = cfg_wdata;
            if (in_valid && in_ready)
                result_fifo.push_back(predict_request(cmd, req_size, free_addr));
            if (out_valid && out_ready) begin
                if (result_fifo.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected transfer: status %0d addr %h", status, result_addr);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = result_fifo.pop_front();
                    if (want.status !== status || want.addr !== result_addr) begin
                        if (fail_count < 10)
                            $display("mismatch: expected status %0d addr %h, got %0d %h",
                                     want.status, want.addr, status, result_addr);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Testbench top for the buddy block allocator: stimulus, handshake idling and verdict.
`default_nettype none
module tb_top;
    import bba_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [31:0]      cfg_wdata = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             cmd = CMD_ALLOC;
    logic [REQ_W-1:0] req_size = '0;
    logic [31:0]      free_addr = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       status;
    logic [31:0]      result_addr;
    int               fail_count;
    int               pending;
    bit               quiet = 1'b0;
    int               stall_left = 0;
    int               idle_cycles = 0;
    logic [31:0]      base_now = HEAP_BASE_RESET;
    logic [31:0]      live_addrs [$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    buddy_block_allocator_unit uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .req_size(req_size),
        .free_addr(free_addr), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_addr(result_addr)
    );

    bba_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .req_size(req_size),
        .free_addr(free_addr), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_addr(result_addr),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 19) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
        if (out_valid && out_ready && status == ST_OK && live_addrs.size() < 64)
            live_addrs.push_back(result_addr);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic transfer(input logic c, input logic [REQ_W-1:0] rs, input logic [31:0] fa);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        req_size <= rs;
        free_addr <= fa;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic drain_and_set(input logic [31:0] base);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_we <= 1'b0;
        base_now = base;
        live_addrs.delete();
    endtask

    task automatic free_live(input int k);
        int sel;
        logic [31:0] a;
        if (live_addrs.size() == 0) begin
            transfer(CMD_FREE, '0, base_now + 32'($urandom_range(0, HEAP_BYTES - 1)));
            return;
        end
        sel = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[sel];
        live_addrs.delete(sel);
        if (k == 0)
            a = a + $urandom_range(0, UNIT_BYTES - 1);
        transfer(CMD_FREE, '0, a);
    endtask

    task automatic random_phase(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                transfer(CMD_ALLOC, REQ_W'($urandom_range(0, 600)), $urandom);
            else if (r < 50)
                transfer(CMD_ALLOC, REQ_W'($urandom), $urandom);
            else if (r < 85)
                free_live($urandom_range(0, 3));
            else if (r < 93)
                transfer(CMD_FREE, REQ_W'($urandom),
                         base_now + 32'($urandom_range(0, HEAP_BYTES - 1)));
            else
                transfer(CMD_FREE, REQ_W'($urandom), $urandom);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        transfer(CMD_ALLOC, 15'd0, 32'hFFFF_FFFF);
        transfer(CMD_ALLOC, 15'd31, '0);
        transfer(CMD_ALLOC, 15'd33, '0);
        transfer(CMD_ALLOC, 15'd16384, '0);
        transfer(CMD_ALLOC, 15'd16385, '0);
        transfer(CMD_ALLOC, 15'h7FFF, '0);
        transfer(CMD_FREE, '0, base_now + 32'd5);
        transfer(CMD_FREE, '0, base_now + 32'd5);
        transfer(CMD_FREE, '0, base_now + 32'd64);
        transfer(CMD_FREE, '0, base_now + 32'd96);
        transfer(CMD_FREE, '0, base_now + 32'd32);
        transfer(CMD_FREE, '0, base_now - 32'd1);
        transfer(CMD_FREE, '0, base_now + 32'd16384);
        transfer(CMD_FREE, '0, 32'hFFFF_FFFF);
        transfer(CMD_ALLOC, 15'd16384, '0);
        transfer(CMD_ALLOC, 15'd32, '0);
        transfer(CMD_FREE, '0, base_now + 32'd16383);
        transfer(CMD_FREE, '0, base_now);
        transfer(CMD_ALLOC, 15'd8192, '0);
        transfer(CMD_ALLOC, 15'd8193, '0);
        transfer(CMD_ALLOC, 15'd8192, '0);
        transfer(CMD_FREE, '0, base_now + 32'd8192);
        transfer(CMD_FREE, '0, base_now);

        drain_and_set(32'h0000_0000);
        random_phase(140);
        drain_and_set(32'hFFFF_F000);
        random_phase(140);
        drain_and_set(32'hFFFF_FFFF);
        random_phase(140);
        drain_and_set($urandom);
        quiet = 1'b1;
        random_phase(140);

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
